/* sv/charge_supervisor_fsm_macros.svh */
// Assertion macros for the charge supervisor.
// Included by the top level, which supplies i_clk and i_rst_n in scope.
`ifndef CHARGE_SUPERVISOR_FSM_MACROS_SVH
`define CHARGE_SUPERVISOR_FSM_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CSF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("charge supervisor check failed");

// Next-cycle implication, checked outside reset.
`define CSF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("charge supervisor check failed");

`endif

/* sv/csf_pkg.sv */
// Shared types and constants for the charge supervisor.
// No dependencies; imported by every module of the block.
package csf_pkg;

    localparam int unsigned CODE_W = 16;
    localparam int unsigned IDX_W  = 3;
    localparam int unsigned IN_W   = 88;
    localparam int unsigned OUT_W  = 40;

    // Register indexes on the configuration channel.
    localparam logic [IDX_W-1:0] REG_CELL_FULL  = 3'd0;
    localparam logic [IDX_W-1:0] REG_MAX_SPREAD = 3'd1;
    localparam logic [IDX_W-1:0] REG_HB_LIMIT   = 3'd2;
    localparam logic [IDX_W-1:0] REG_VOLT_CAP   = 3'd3;
    localparam logic [IDX_W-1:0] REG_CURR_CAP   = 3'd4;

    // Reset values.
    localparam logic [CODE_W-1:0] RST_CELL_FULL  = 16'd42000;
    localparam logic [CODE_W-1:0] RST_MAX_SPREAD = 16'd500;
    localparam logic [CODE_W-1:0] RST_HB_LIMIT   = 16'd5000;
    localparam logic [CODE_W-1:0] RST_VOLT_CAP   = 16'd600;
    localparam logic [CODE_W-1:0] RST_CURR_CAP   = 16'd10;
    localparam logic [CODE_W-1:0] RST_REQ_VOLTS  = 16'd600;
    localparam logic [CODE_W-1:0] RST_REQ_AMPS   = 16'd10;

    // Supervisor state codes as seen on the result stream.
    localparam logic [2:0] CODE_STANDBY = 3'd0;
    localparam logic [2:0] CODE_READY   = 3'd1;
    localparam logic [2:0] CODE_REQUEST = 3'd2;
    localparam logic [2:0] CODE_BALANCE = 3'd3;
    localparam logic [2:0] CODE_FAULT   = 3'd4;

    typedef struct packed {
        logic [CODE_W-1:0] cell_full;
        logic [CODE_W-1:0] max_spread;
        logic [CODE_W-1:0] hb_limit;
        logic [CODE_W-1:0] volt_cap;
        logic [CODE_W-1:0] curr_cap;
    } t_cfg;

    typedef struct packed {
        logic              pack_faulted;
        logic              link_error;
        logic              charger_ok;
        logic              charger_starting;
        logic [2:0]        charger_hw_faults;
        logic [CODE_W-1:0] heartbeat_age;
        logic [CODE_W-1:0] cell_max_code;
        logic [CODE_W-1:0] cell_min_code;
        logic              cells_present;
        logic              setpoint_valid;
        logic [CODE_W-1:0] setpoint_voltage;
        logic [CODE_W-1:0] setpoint_current;
    } t_item;

    typedef struct packed {
        logic              charge_enable;
        logic [CODE_W-1:0] voltage_command;
        logic [CODE_W-1:0] current_command;
        logic [2:0]        supervisor_state;
        logic              balance_active;
        logic              fault_status;
    } t_result;

    // Handshake between the input stage and the step engine.
    typedef struct packed {
        logic valid;
        logic take;
    } t_link;

    // Engine status seen by the top level.
    typedef struct packed {
        logic [2:0] state;
        logic       fire;
    } t_eng_status;

endpackage

/* sv/charge_supervisor_fsm.sv */
// Charge supervisor top level: config registers, input stage and step engine.
// Input moves through the input register, then the result register, to m_axis.
// Throughput: one item per cycle while the result stream is not stalled.
// Reset: synchronous, active low; state returns to standby, setpoint to 600/10,
// configuration registers to their defaults, and both streams empty.
module charge_supervisor_fsm
    import csf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration write channel.
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [CODE_W-1:0] i_cfg_data,
    // Input stream.
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // pack_faulted, link_error, charger_ok, charger_starting, charger_hw_faults[3],
    // heartbeat_age[16], max cell code[16], min cell code[16], cells_present,
    // setpoint_voltage[16], setpoint_current[16]
    input  logic [IN_W-1:0]   s_axis_tdata,
    // setpoint_valid
    input  logic              s_axis_tuser,
    // Result stream.
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // charge_enable, voltage_command[16], current_command[16], supervisor_state[3],
    // balance_active, fault_status, two zero pad bits
    output logic [OUT_W-1:0]  m_axis_tdata
);

    t_cfg        cfg;
    t_item       item;
    logic        item_valid;
    t_link       link;
    t_result     result;
    t_eng_status status;

    // Result-side conditions watched by the assertions.
    logic        cmd_on;
    logic        cmd_off;
    logic        cmd_in_request;
    logic        cmd_zero;

    assign o_cfg_ready = 1'b1;

    csf_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    csf_in_stage u_in (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .i_take   (link.take),
        .o_item   (item),
        .o_valid  (item_valid)
    );

    assign link.valid = item_valid;

    csf_engine u_eng (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_item      (item),
        .i_valid     (link.valid),
        .o_take      (link.take),
        .o_result    (result),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_status    (status)
    );

    // Pack the result, lowest field in the lowest bits.
    assign m_axis_tdata = {2'b00,
                           result.fault_status,
                           result.balance_active,
                           result.supervisor_state,
                           result.current_command,
                           result.voltage_command,
                           result.charge_enable};

    // Conditions on the waiting result transaction.
    assign cmd_on         = m_axis_tvalid && result.charge_enable;
    assign cmd_off        = m_axis_tvalid && !result.charge_enable;
    assign cmd_in_request = (result.supervisor_state == CODE_REQUEST) && !result.fault_status;
    assign cmd_zero       = (result.voltage_command == '0) && (result.current_command == '0);

    `include "charge_supervisor_fsm_macros.svh"

    // Fault is left only through reset.
    `CSF_ASSERT_NEXT(a_fault_sticky, status.state == CODE_FAULT, status.state == CODE_FAULT)
    // An enabled command only comes out of a step that stays in requesting.
    `CSF_ASSERT_NOW(a_enable_in_request, cmd_on, cmd_in_request)
    // A disabled command carries zero caps.
    `CSF_ASSERT_NOW(a_off_is_zero, cmd_off, cmd_zero)
    // A step that fires always leaves a result behind.
    `CSF_ASSERT_NEXT(a_fire_gives_result, status.fire, m_axis_tvalid)

endmodule

/* sv/csf_cfg_regs.sv */
// Configuration register file of the charge supervisor.
// Depends on csf_pkg for the register indexes and reset values.
module csf_cfg_regs
    import csf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CODE_W-1:0] i_cfg_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;

    // A write lands whenever the channel is valid; unused indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cell_full  <= RST_CELL_FULL;
            r_cfg.max_spread <= RST_MAX_SPREAD;
            r_cfg.hb_limit   <= RST_HB_LIMIT;
            r_cfg.volt_cap   <= RST_VOLT_CAP;
            r_cfg.curr_cap   <= RST_CURR_CAP;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_CELL_FULL:  r_cfg.cell_full  <= i_cfg_data;
                REG_MAX_SPREAD: r_cfg.max_spread <= i_cfg_data;
                REG_HB_LIMIT:   r_cfg.hb_limit   <= i_cfg_data;
                REG_VOLT_CAP:   r_cfg.volt_cap   <= i_cfg_data;
                REG_CURR_CAP:   r_cfg.curr_cap   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* sv/csf_in_stage.sv */
// Input register of the charge supervisor: unpacks and holds one item.
// Depends on csf_pkg for the item layout.
module csf_in_stage
    import csf_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_tvalid,
    output logic            o_tready,
    input  logic [IN_W-1:0] i_tdata,
    input  logic            i_tuser,
    input  logic            i_take,
    output t_item           o_item,
    output logic            o_valid
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    // The register may load when empty or when the engine takes its item.
    assign o_tready = !r_valid || i_take;

    // Unpack the stream word, lowest field in the lowest bits.
    always_comb begin
        n_item.pack_faulted      = i_tdata[0];
        n_item.link_error        = i_tdata[1];
        n_item.charger_ok        = i_tdata[2];
        n_item.charger_starting  = i_tdata[3];
        n_item.charger_hw_faults = i_tdata[6:4];
        n_item.heartbeat_age     = i_tdata[22:7];
        n_item.cell_max_code     = i_tdata[38:23];
        n_item.cell_min_code     = i_tdata[54:39];
        n_item.cells_present     = i_tdata[55];
        n_item.setpoint_voltage  = i_tdata[71:56];
        n_item.setpoint_current  = i_tdata[87:72];
        n_item.setpoint_valid    = i_tuser;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_tready) begin
            r_valid <= i_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tready && i_tvalid) begin
            r_item <= n_item;
        end
    end

    assign o_item  = r_item;
    assign o_valid = r_valid;

endmodule

/* sv/csf_engine.sv */
// Supervisor state machine and result register of the charge supervisor.
// Depends on csf_pkg for the item, result and configuration types.
module csf_engine
    import csf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_item       i_item,
    input  logic        i_valid,
    output logic        o_take,
    output t_result     o_result,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_eng_status o_status
);

    typedef enum logic [2:0] {
        S_STANDBY = CODE_STANDBY,
        S_READY   = CODE_READY,
        S_REQUEST = CODE_REQUEST,
        S_BALANCE = CODE_BALANCE,
        S_FAULT   = CODE_FAULT
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [CODE_W-1:0] r_req_v;
    logic [CODE_W-1:0] r_req_a;
    logic [CODE_W-1:0] n_req_v;
    logic [CODE_W-1:0] n_req_a;
    logic              r_out_valid;
    t_result           r_result;
    t_result           n_result;
    logic              fire;

    logic              pack_ok;
    logic              okay;
    logic              ready;
    logic              permitted;
    logic [CODE_W-1:0] spread;
    logic              needs_bal;

    // An item moves on when the result register is free or being drained.
    assign fire   = i_valid && (!r_out_valid || i_out_ready);
    assign o_take = fire;

    // Health and policy conditions of the current item.
    always_comb begin
        pack_ok   = !i_item.pack_faulted && !i_item.link_error;
        okay      = pack_ok && (i_item.charger_hw_faults == 3'd0);
        ready     = (i_item.heartbeat_age <= i_cfg.hb_limit) && i_item.charger_ok
                    && !i_item.charger_starting;
        permitted = (i_item.cell_max_code < i_cfg.cell_full) && pack_ok && ready;
        spread    = i_item.cell_max_code - i_item.cell_min_code;
        needs_bal = i_item.cells_present && (spread > i_cfg.max_spread);
    end

    // Next state, stored setpoint and result of one step.
    always_comb begin
        n_state  = r_state;
        n_req_v  = r_req_v;
        n_req_a  = r_req_a;
        n_result = '0;
        if (r_state != S_FAULT && i_item.setpoint_valid) begin
            n_req_v = i_item.setpoint_voltage;
            n_req_a = i_item.setpoint_current;
        end
        unique case (r_state)
            S_STANDBY: begin
                if (!okay) begin
                    n_state = S_FAULT;
                end else if (permitted) begin
                    n_state = S_READY;
                end
            end
            S_READY: begin
                if (!okay) begin
                    n_state = S_FAULT;
                end else if (!permitted) begin
                    n_state = S_STANDBY;
                end else if (needs_bal) begin
                    n_state = S_BALANCE;
                end else begin
                    n_state = S_REQUEST;
                end
            end
            S_REQUEST: begin
                if (!okay) begin
                    n_state = S_FAULT;
                end else if (!permitted) begin
                    n_state = S_STANDBY;
                end else if (needs_bal) begin
                    n_state = S_BALANCE;
                end else begin
                    n_result.charge_enable   = 1'b1;
                    n_result.voltage_command = (n_req_v > i_cfg.volt_cap) ? i_cfg.volt_cap
                                                                          : n_req_v;
                    n_result.current_command = (n_req_a > i_cfg.curr_cap) ? i_cfg.curr_cap
                                                                          : n_req_a;
                end
            end
            S_BALANCE: begin
                if (!okay || !i_item.cells_present) begin
                    n_state = S_FAULT;
                end else if (!permitted) begin
                    n_state = S_STANDBY;
                end else begin
                    n_result.balance_active = 1'b1;
                    if (!needs_bal) begin
                        n_state = S_READY;
                    end
                end
            end
            default: begin
                // Fault is sticky; the item is ignored.
                n_state               = S_FAULT;
                n_result.fault_status = 1'b1;
            end
        endcase
        n_result.supervisor_state = n_state;
    end

    // State, stored setpoint and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_STANDBY;
            r_req_v     <= RST_REQ_VOLTS;
            r_req_a     <= RST_REQ_AMPS;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_state     <= n_state;
                r_req_v     <= n_req_v;
                r_req_a     <= n_req_a;
                r_result    <= n_result;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_result       = r_result;
    assign o_out_valid    = r_out_valid;
    assign o_status.state = r_state;
    assign o_status.fire  = fire;

endmodule

/* tb/sv/tb_charge_supervisor_fsm.sv */
// Self-checking testbench for the charge supervisor state machine.
// Depends on csf_pkg and charge_supervisor_fsm; drives random and directed supervisor
// ticks and checks every command against a cycle-free behavioral predictor.
module tb_charge_supervisor_fsm
    import csf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Register index that no register answers to.
    localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;

    // One queued tick for the driver, optionally held until the block has drained.
    typedef struct {
        t_item item;
        bit    drain_first;
    } t_feed;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [IDX_W-1:0]  i_cfg_index = '0;
    logic [CODE_W-1:0] i_cfg_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;
    logic              s_axis_tuser = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;

    // Predictor state: registers, supervisor state and the stored setpoint.
    t_cfg              model_cfg;
    logic [2:0]        sup_state;
    logic [CODE_W-1:0] held_volts;
    logic [CODE_W-1:0] held_amps;

    t_feed             tick_feed[$];
    t_result           pending_commands[$];
    bit                may_be_balancing;
    bit                calm_tx;
    bit                calm_rx;
    int unsigned       tx_gap;
    int unsigned       rx_hold;
    int unsigned       err_count;
    int unsigned       n_sent;
    int unsigned       n_checked;
    int unsigned       n_enabled;
    int unsigned       n_settings;
    int unsigned       state_seen[5];
    t_item             seen_tick;
    t_result           got_cmd;
    t_result           want_cmd;
    logic [1:0]        pad_bits;

    charge_supervisor_fsm i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Run stops here if the block hangs.
    initial begin
        #2_000_000;
        $display("Timeout: traffic stopped before the run completed.");
        $display("TEST FAILED");
        $finish;
    end

    // Wait between transactions: none in a calm stretch, else a random one.
    function automatic int unsigned pick_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 3);
    endfunction

    // Code value that favors both ends of the range.
    function automatic logic [CODE_W-1:0] pick_code();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return CODE_W'($urandom);
        endcase
    endfunction

    // Printable form of one command.
    function automatic string fmt_cmd(input t_result c);
        return $sformatf("en=%0b v=%0d i=%0d st=%0d bal=%0b flt=%0b",
                         c.charge_enable, c.voltage_command, c.current_command,
                         c.supervisor_state, c.balance_active, c.fault_status);
    endfunction

    // Advance the supervisor by one tick and return the command it should emit.
    function automatic t_result advance_supervisor(input t_item it);
        t_result           r;
        logic              line_ok;
        logic              all_ok;
        logic              charger_ready;
        logic              may_charge;
        logic              wants_bal;
        logic [CODE_W-1:0] spread;
        r = '0;
        if (sup_state == CODE_FAULT) begin
            // Fault is sticky and ignores the whole tick, setpoint included.
            r.fault_status = 1'b1;
        end else begin
            line_ok = !it.pack_faulted && !it.link_error;
            all_ok = line_ok && (it.charger_hw_faults == 3'd0);
            charger_ready = (it.heartbeat_age <= model_cfg.hb_limit) && it.charger_ok
                            && !it.charger_starting;
            may_charge = (it.cell_max_code < model_cfg.cell_full) && line_ok && charger_ready;
            spread = it.cell_max_code - it.cell_min_code;
            wants_bal = it.cells_present && (spread > model_cfg.max_spread);

            // A new setpoint lands before the state decision of the same tick.
            if (it.setpoint_valid) begin
                held_volts = it.setpoint_voltage;
                held_amps = it.setpoint_current;
            end

            case (sup_state)
                CODE_STANDBY: begin
                    if (!all_ok) begin
                        sup_state = CODE_FAULT;
                    end else if (may_charge) begin
                        sup_state = CODE_READY;
                    end
                end
                CODE_READY: begin
                    if (!all_ok) begin
                        sup_state = CODE_FAULT;
                    end else if (!may_charge) begin
                        sup_state = CODE_STANDBY;
                    end else if (wants_bal) begin
                        sup_state = CODE_BALANCE;
                    end else begin
                        sup_state = CODE_REQUEST;
                    end
                end
                CODE_REQUEST: begin
                    if (!all_ok) begin
                        sup_state = CODE_FAULT;
                    end else if (!may_charge) begin
                        sup_state = CODE_STANDBY;
                    end else if (wants_bal) begin
                        sup_state = CODE_BALANCE;
                    end else begin
                        r.charge_enable = 1'b1;
                        r.voltage_command = (held_volts > model_cfg.volt_cap) ?
                                            model_cfg.volt_cap : held_volts;
                        r.current_command = (held_amps > model_cfg.curr_cap) ?
                                            model_cfg.curr_cap : held_amps;
                    end
                end
                CODE_BALANCE: begin
                    // Losing cell data while balancing counts as a fault.
                    if (!all_ok || !it.cells_present) begin
                        sup_state = CODE_FAULT;
                    end else if (!may_charge) begin
                        sup_state = CODE_STANDBY;
                    end else begin
                        r.balance_active = 1'b1;
                        if (!wants_bal) begin
                            sup_state = CODE_READY;
                        end
                    end
                end
                default: ;
            endcase
        end
        r.supervisor_state = sup_state;
        return r;
    endfunction

    // Queue a tick and remember whether it may leave the block balancing.
    task automatic queue_item(input t_item it, input bit drain);
        logic [CODE_W-1:0] spread;
        spread = it.cell_max_code - it.cell_min_code;
        tick_feed.push_back('{it, drain});
        may_be_balancing = it.cells_present && (spread > model_cfg.max_spread);
    endtask

    // Healthy-pack tick with the given charger and cell values.
    task automatic put(input logic [CODE_W-1:0] age, input logic [CODE_W-1:0] hi,
                       input logic [CODE_W-1:0] lo, input bit cells, input bit spv,
                       input logic [CODE_W-1:0] sv, input logic [CODE_W-1:0] si,
                       input bit ok, input bit starting, input bit drain);
        t_item it;
        it = '0;
        it.charger_ok = ok;
        it.charger_starting = starting;
        it.heartbeat_age = age;
        it.cell_max_code = hi;
        it.cell_min_code = lo;
        it.cells_present = cells;
        it.setpoint_valid = spv;
        it.setpoint_voltage = sv;
        it.setpoint_current = si;
        queue_item(it, drain);
    endtask

    // Random tick that never faults the pack: mostly permitted, sometimes one
    // permission missing, with cell data dropped only when not balancing.
    function automatic t_item rand_item();
        t_item       it;
        int unsigned roll;
        int unsigned d;
        it = '0;
        it.charger_ok = 1'b1;
        it.heartbeat_age = CODE_W'($urandom_range(0, model_cfg.hb_limit));
        it.cell_max_code = (model_cfg.cell_full == '0) ? '0 :
                           CODE_W'($urandom_range(0, model_cfg.cell_full - 1));
        roll = $urandom_range(0, 99);
        if (roll < 20) begin
            case ($urandom_range(0, 3))
                0: it.charger_ok = 1'b0;
                1: it.charger_starting = 1'b1;
                2: begin
                    if (model_cfg.hb_limit != '1) begin
                        it.heartbeat_age =
                            CODE_W'($urandom_range(model_cfg.hb_limit + 1, 16'hFFFF));
                    end else begin
                        it.charger_ok = 1'b0;
                    end
                end
                default: it.cell_max_code =
                    CODE_W'($urandom_range(model_cfg.cell_full, 16'hFFFF));
            endcase
        end else if (roll < 28) begin
            it.heartbeat_age = CODE_W'($urandom);
            it.cell_max_code = CODE_W'($urandom);
            it.charger_starting = 1'($urandom_range(0, 1));
        end

        // Spread mostly within the limit, sometimes beyond it, now and then anything.
        roll = $urandom_range(0, 15);
        if (roll == 0) begin
            d = $urandom_range(0, 16'hFFFF);
        end else if (roll < 3 && model_cfg.max_spread != '1) begin
            d = $urandom_range(model_cfg.max_spread + 1, 16'hFFFF);
        end else begin
            d = $urandom_range(0, model_cfg.max_spread);
        end
        it.cell_min_code = it.cell_max_code - CODE_W'(d);
        it.cells_present = may_be_balancing ? 1'b1 : ($urandom_range(0, 7) != 0);
        it.setpoint_valid = ($urandom_range(0, 3) == 0);
        it.setpoint_voltage = pick_code();
        it.setpoint_current = pick_code();
        return it;
    endfunction

    task automatic run_random(input int unsigned count);
        calm_tx = ($urandom_range(0, 3) == 0);
        calm_rx = ($urandom_range(0, 3) == 0);
        repeat (count) begin
            queue_item(rand_item(), $urandom_range(0, 49) == 0);
        end
    endtask

    // Block until every queued tick has been sent and answered.
    task automatic wait_idle();
        while (tick_feed.size() != 0 || s_axis_tvalid || pending_commands.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // One register write; called at a rising edge with the block idle.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CODE_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_CELL_FULL:  model_cfg.cell_full = val;
            REG_MAX_SPREAD: model_cfg.max_spread = val;
            REG_HB_LIMIT:   model_cfg.hb_limit = val;
            REG_VOLT_CAP:   model_cfg.volt_cap = val;
            REG_CURR_CAP:   model_cfg.curr_cap = val;
            default: ;
        endcase
    endtask

    task automatic load_settings(input t_cfg c);
        write_reg(REG_CELL_FULL, c.cell_full);
        write_reg(REG_MAX_SPREAD, c.max_spread);
        write_reg(REG_HB_LIMIT, c.hb_limit);
        write_reg(REG_VOLT_CAP, c.volt_cap);
        write_reg(REG_CURR_CAP, c.curr_cap);
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic report_error(input string msg);
        err_count++;
        if (err_count <= 10) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endtask

    // Input driver: one transaction per queued tick, random gaps between them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_gap = 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (tx_gap != 0) begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (tick_feed.size() != 0 && !(tick_feed[0].drain_first &&
                         (s_axis_tvalid || pending_commands.size() != 0))) begin
                s_axis_tdata <= {tick_feed[0].item.setpoint_current,
                                 tick_feed[0].item.setpoint_voltage,
                                 tick_feed[0].item.cells_present,
                                 tick_feed[0].item.cell_min_code,
                                 tick_feed[0].item.cell_max_code,
                                 tick_feed[0].item.heartbeat_age,
                                 tick_feed[0].item.charger_hw_faults,
                                 tick_feed[0].item.charger_starting,
                                 tick_feed[0].item.charger_ok,
                                 tick_feed[0].item.link_error,
                                 tick_feed[0].item.pack_faulted};
                s_axis_tuser <= tick_feed[0].item.setpoint_valid;
                s_axis_tvalid <= 1'b1;
                void'(tick_feed.pop_front());
                tx_gap = pick_gap(calm_tx);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: predicts on each accepted tick, checks each accepted command,
    // and stalls the result side at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_hold = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                {seen_tick.setpoint_current, seen_tick.setpoint_voltage,
                 seen_tick.cells_present, seen_tick.cell_min_code, seen_tick.cell_max_code,
                 seen_tick.heartbeat_age, seen_tick.charger_hw_faults,
                 seen_tick.charger_starting, seen_tick.charger_ok, seen_tick.link_error,
                 seen_tick.pack_faulted} = s_axis_tdata;
                seen_tick.setpoint_valid = s_axis_tuser;
                pending_commands.push_back(advance_supervisor(seen_tick));
                n_sent++;
            end

            if (m_axis_tvalid && m_axis_tready) begin
                {pad_bits, got_cmd.fault_status, got_cmd.balance_active,
                 got_cmd.supervisor_state, got_cmd.current_command, got_cmd.voltage_command,
                 got_cmd.charge_enable} = m_axis_tdata;
                if (pending_commands.size() == 0) begin
                    report_error("command transaction with no tick waiting for it");
                end else begin
                    want_cmd = pending_commands.pop_front();
                    n_checked++;
                    if (got_cmd.charge_enable !== want_cmd.charge_enable
                        || got_cmd.voltage_command !== want_cmd.voltage_command
                        || got_cmd.current_command !== want_cmd.current_command
                        || got_cmd.supervisor_state !== want_cmd.supervisor_state
                        || got_cmd.balance_active !== want_cmd.balance_active
                        || got_cmd.fault_status !== want_cmd.fault_status) begin
                        report_error($sformatf("command %0d: want %s, got %s", n_checked,
                                               fmt_cmd(want_cmd), fmt_cmd(got_cmd)));
                    end
                    if (want_cmd.supervisor_state <= CODE_FAULT) begin
                        state_seen[want_cmd.supervisor_state]++;
                    end
                    if (want_cmd.charge_enable) begin
                        n_enabled++;
                    end
                end
                rx_hold = pick_gap(calm_rx);
            end

            if (rx_hold != 0) begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Stimulus sequence and end of run.
    initial begin : stimulus
        t_cfg        c;
        t_item       it;
        logic [95:0] raw;
        int unsigned cause;

        model_cfg = {RST_CELL_FULL, RST_MAX_SPREAD, RST_HB_LIMIT, RST_VOLT_CAP, RST_CURR_CAP};
        sup_state = CODE_STANDBY;
        held_volts = RST_REQ_VOLTS;
        held_amps = RST_REQ_AMPS;
        may_be_balancing = 1'b0;
        calm_tx = 1'b0;
        calm_rx = 1'b0;
        err_count = 0;
        n_sent = 0;
        n_checked = 0;
        n_enabled = 0;
        n_settings = 1;
        foreach (state_seen[k]) state_seen[k] = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed walk through every state but fault under the reset register values.
        put(0, 0, 0, 1, 0, 0, 0, 1, 0, 0);                  // standby to ready
        put(0, 20000, 19900, 1, 1, 16'hFFFF, 16'hFFFF, 1, 0, 0); // to requesting, off
        put(100, 20000, 19900, 1, 0, 0, 0, 1, 0, 1);         // clamped to both caps
        put(5000, 41999, 41999, 1, 1, 100, 3, 1, 0, 0);      // same-tick setpoint
        put(5000, 100, 16'hFFFF, 0, 0, 0, 0, 1, 0, 0);       // no cell data, inverted
        put(0, 1000, 2000, 1, 0, 0, 0, 1, 0, 0);             // inverted cells: balance
        put(0, 1000, 400, 1, 0, 0, 0, 1, 0, 0);              // keep balancing
        put(0, 1000, 500, 1, 0, 0, 0, 1, 0, 0);              // spread at limit: ready
        put(5001, 0, 0, 1, 0, 0, 0, 1, 0, 0);                // stale heartbeat
        put(0, 16'hFFFF, 16'hFFFF, 1, 1, 0, 0, 1, 0, 0);     // full pack
        put(0, 42000, 42000, 1, 0, 0, 0, 1, 0, 0);           // exactly at threshold
        put(0, 0, 0, 1, 0, 0, 0, 1, 0, 0);
        put(0, 0, 0, 1, 0, 0, 0, 1, 1, 0);                   // charger still starting
        put(0, 0, 0, 1, 0, 0, 0, 1, 0, 0);
        put(0, 0, 0, 0, 0, 0, 0, 1, 0, 0);
        put(0, 0, 0, 1, 0, 0, 0, 1, 0, 0);                   // zero setpoint
        put(0, 0, 0, 1, 1, 600, 10, 1, 0, 0);
        put(0, 0, 0, 1, 1, 601, 11, 1, 0, 0);
        put(0, 0, 0, 1, 0, 0, 0, 0, 0, 0);                   // charger not okay
        put(0, 0, 0, 1, 0, 0, 0, 1, 0, 0);
        put(0, 30000, 0, 1, 0, 0, 0, 1, 0, 0);               // ready to balancing
        put(0, 42000, 0, 1, 0, 0, 0, 1, 0, 0);               // balancing, pack full
        put(16'hFFFF, 16'hFFFF, 0, 1, 1, 16'hFFFF, 0, 1, 0, 0);
        wait_idle();

        // A write to an unused index must leave every register alone.
        write_reg(REG_SPARE, 16'hFFFF);
        i_cfg_valid <= 1'b0;
        run_random(150);
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: c = '0;
                1: c = '1;
                2: c = {16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0};
                3: c = {16'd1, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF};
                default: begin
                    c.cell_full = CODE_W'($urandom_range(1000, 16'hFFFF));
                    c.max_spread = CODE_W'($urandom_range(0, 3000));
                    c.hb_limit = CODE_W'($urandom);
                    c.volt_cap = CODE_W'($urandom);
                    c.curr_cap = CODE_W'($urandom);
                end
            endcase
            load_settings(c);
            run_random((p == 0) ? 40 : (p == 3) ? 100 : 120);
            wait_idle();
        end

        // Last phase: walk into requesting, trip the sticky fault, then send noise.
        c = {RST_CELL_FULL, RST_MAX_SPREAD, RST_HB_LIMIT, pick_code(), pick_code()};
        load_settings(c);
        repeat (3) put(0, 100, 100, 1, 0, 0, 0, 1, 0, 0);
        cause = $urandom_range(0, 3);
        it = '0;
        it.charger_ok = 1'b1;
        it.cells_present = 1'b1;
        case (cause)
            0: it.pack_faulted = 1'b1;
            1: it.link_error = 1'b1;
            2: it.charger_hw_faults = 3'($urandom_range(1, 7));
            default: begin
                // Enter balancing, then lose the cell data.
                put(0, 1000, 0, 1, 0, 0, 0, 1, 0, 0);
                it.cells_present = 1'b0;
            end
        endcase
        queue_item(it, 1'b0);
        repeat (40) begin
            raw = {$urandom, $urandom, $urandom};
            queue_item(raw[$bits(t_item)-1:0], 1'b0);
        end
        wait_idle();
        repeat (8) @(posedge i_clk);

        if (pending_commands.size() != 0) begin
            report_error($sformatf("%0d expected commands never arrived",
                                   pending_commands.size()));
        end

        $display("Sent %0d ticks under %0d register settings; %0d commands checked, %0d bad.",
                 n_sent, n_settings, n_checked, err_count);
        $display(
            "States: %0d standby, %0d ready, %0d requesting (%0d on), %0d balancing, %0d fault.",
            state_seen[CODE_STANDBY], state_seen[CODE_READY], state_seen[CODE_REQUEST],
            n_enabled, state_seen[CODE_BALANCE], state_seen[CODE_FAULT]);
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
